/* hdl/sfcd_pkg.sv */
// Shared types, constants and arithmetic helpers for the sensor frame CRC decoder.
`default_nettype none
package sfcd_pkg;

  localparam logic [15:0] CrcSeed      = 16'hFFFF;
  localparam logic [15:0] CrcPoly      = 16'hA001;
  localparam logic [15:0] Recip10      = 16'hCCCD;
  localparam int          Recip10Shift = 19;
  localparam logic [2:0]  DataLen      = 3'd6;
  localparam logic [2:0]  LastPos      = 3'd7;
  localparam int          CapDepth     = 5;
  localparam int          ValW         = 13;

  typedef struct packed {
    logic        crc_ok;
    logic [15:0] hum_raw;
    logic        temp_neg;
    logic [14:0] temp_mag;
  } frame_info_t;

  // One reflected CRC-16 byte step, unrolled over eight bits.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Exact quotient by ten for any 16-bit value, by reciprocal multiply.
  function automatic logic [ValW-1:0] div10(input logic [15:0] x);
    logic [31:0] p;
    p = 32'(x) * 32'(Recip10);
    return p[Recip10Shift +: ValW];
  endfunction

endpackage
`default_nettype wire

/* hdl/sfcd_frame_track.sv */
// Frame position counter, running CRC and captured payload bytes.
`default_nettype none
module sfcd_frame_track
  import sfcd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic [7:0]  data_byte,
  input  wire logic        frame_start,
  output frame_info_t      info,
  output logic             is_last
);

  logic [2:0]  pos_r, pos_nxt, pos;
  logic [15:0] crc_r, crc_nxt, crc_base;
  logic [7:0]  cap_r [CapDepth];

  assign pos      = frame_start ? 3'd0 : pos_r;
  assign crc_base = frame_start ? CrcSeed : crc_r;
  assign is_last  = (pos == LastPos);
  assign pos_nxt  = pos + 3'd1;

  always_comb begin
    priority if (pos < DataLen) begin
      crc_nxt = crc_feed(crc_base, data_byte);
    end else if (pos == LastPos) begin
      crc_nxt = CrcSeed;
    end else begin
      crc_nxt = crc_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 3'd0;
      crc_r <= CrcSeed;
    end else if (step) begin
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
    end
  end

  for (genvar i = 0; i < CapDepth; i++) begin : g_cap
    always_ff @(posedge clk) begin
      if (step && (pos == 3'(i + 2))) begin
        cap_r[i] <= data_byte;
      end
    end
  end

  assign info.crc_ok   = ({data_byte, cap_r[4]} == crc_base);
  assign info.hum_raw  = {cap_r[0], cap_r[1]};
  assign info.temp_neg = cap_r[2][7];
  assign info.temp_mag = {cap_r[2][6:0], cap_r[3]};

endmodule
`default_nettype wire

/* hdl/sfcd_result.sv */
// Scaling of the frame readings and the last good value hold.
`default_nettype none
module sfcd_result
  import sfcd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   done,
  input  wire frame_info_t            info,
  output logic                        crc_ok,
  output logic [ValW-1:0]             humidity_whole,
  output logic signed [ValW-1:0]      temperature_whole
);

  logic [ValW-1:0] hum_r, hum_nxt;
  logic [ValW-1:0] temp_r, temp_nxt, temp_q;

  assign hum_nxt  = div10(info.hum_raw);
  assign temp_q   = div10({1'b0, info.temp_mag});
  assign temp_nxt = info.temp_neg ? (ValW'(0) - temp_q) : temp_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hum_r  <= '0;
      temp_r <= '0;
    end else if (done && info.crc_ok) begin
      hum_r  <= hum_nxt;
      temp_r <= temp_nxt;
    end
  end

  assign crc_ok            = info.crc_ok;
  assign humidity_whole    = info.crc_ok ? hum_nxt : hum_r;
  assign temperature_whole = info.crc_ok ? temp_nxt : temp_r;

endmodule
`default_nettype wire

/* hdl/sensor_frame_crc_decoder.sv */
// Top level of the sensor frame CRC decoder with input and result registers.
// An accepted byte waits in the input register and is processed from there; the result
// of a frame's final byte is then held in the output register, which drives out_tvalid.
// Throughput is one byte per cycle unless a frame's final byte waits on the output register.
// Reset clears the frame position and the held readings and loads the CRC seed.
`default_nettype none
module sensor_frame_crc_decoder
  import sfcd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // [0] frame_start
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [12:0] humidity_whole, [25:13] temperature_whole
  output logic             out_tuser   // [0] crc_ok
);

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_start_r;
  logic        s1_step;
  logic        is_last;
  logic        out_free;
  logic        in_fire;
  frame_info_t info;

  logic                   res_ok;
  logic [ValW-1:0]        res_hum;
  logic signed [ValW-1:0] res_temp;

  logic                   out_valid_r;
  logic                   out_ok_r;
  logic [ValW-1:0]        out_hum_r;
  logic [ValW-1:0]        out_temp_r;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_step   = s1_valid_r && (!is_last || out_free);
  assign in_tready = !s1_valid_r || s1_step;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r  <= in_tdata;
      s1_start_r <= in_tuser;
    end
  end

  sfcd_frame_track u_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (s1_step),
    .data_byte   (s1_byte_r),
    .frame_start (s1_start_r),
    .info        (info),
    .is_last     (is_last)
  );

  sfcd_result u_result (
    .clk               (clk),
    .rst_n             (rst_n),
    .done              (s1_step && is_last),
    .info              (info),
    .crc_ok            (res_ok),
    .humidity_whole    (res_hum),
    .temperature_whole (res_temp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_step && is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_step && is_last) begin
      out_ok_r   <= res_ok;
      out_hum_r  <= res_hum;
      out_temp_r <= res_temp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ok_r;
  assign out_tdata  = {6'b000000, out_temp_r, out_hum_r};

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_step && is_last |=> out_valid_r)
    else $error("final byte did not load a result");

  a_accept_loads_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted byte lost before processing");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_step |=> s1_valid_r && $stable(s1_byte_r) && $stable(s1_start_r))
    else $error("stalled byte changed in input register");

  a_result_only_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r ##1 out_valid_r |-> $past(s1_step && is_last))
    else $error("result appeared without a final byte");

endmodule
`default_nettype wire
